// File: rtl/vfc_pkg.sv
// shared types and constants of the voxel face culling mesher
// command and status structs, register indexes, face codes, corner table
package vfc_pkg;

  localparam int EXT_W   = 6;
  localparam int COORD_W = 5;

  localparam logic [1:0] REG_EXT_X = 2'd0;
  localparam logic [1:0] REG_EXT_Y = 2'd1;
  localparam logic [1:0] REG_EXT_Z = 2'd2;

  localparam logic [2:0] FACE_LEFT   = 3'd0;
  localparam logic [2:0] FACE_RIGHT  = 3'd1;
  localparam logic [2:0] FACE_BOTTOM = 3'd2;
  localparam logic [2:0] FACE_TOP    = 3'd3;
  localparam logic [2:0] FACE_BACK   = 3'd4;
  localparam logic [2:0] FACE_FRONT  = 3'd5;

  localparam logic [2:0] LAST_CORNER = 3'd5;
  localparam logic [2:0] LAST_READ   = 3'd6;
  localparam logic [2:0] CENTER_READ = 3'd0;

  // corner bits: dx dy dz u_high v_high
  localparam logic [4:0] CORNER_TAB [6][6] = '{
    '{5'b01110, 5'b01000, 5'b00111, 5'b00111, 5'b01000, 5'b00001},
    '{5'b11110, 5'b10111, 5'b11000, 5'b11000, 5'b10111, 5'b10001},
    '{5'b10111, 5'b00101, 5'b10010, 5'b10010, 5'b00101, 5'b00000},
    '{5'b11111, 5'b11010, 5'b01101, 5'b01101, 5'b11010, 5'b01000},
    '{5'b10001, 5'b00011, 5'b01010, 5'b01010, 5'b11000, 5'b10001},
    '{5'b00111, 5'b10101, 5'b11100, 5'b11100, 5'b01110, 5'b00111}
  };

  typedef struct packed {
    logic [EXT_W-1:0] x;
    logic [EXT_W-1:0] y;
    logic [EXT_W-1:0] z;
  } ext_t;

  typedef struct packed {
    logic clr;        // clearing pass step
    logic accept;     // input item taken
    logic issue;      // grid read issued
    logic capture;    // grid read data taken
    logic emit_init;  // pick first open face
    logic emit_step;  // vertex taken downstream
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic center_empty;
    logic rd_last;
    logic any_open;
    logic emit_last;
  } sts_t;

endpackage

// File: rtl/vfc_intf.sv
// valid/ready channels of the voxel face culling mesher
// request items in, vertex items out; no package dependency
interface vfc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [4:0] voxel_x;
  logic [4:0] voxel_y;
  logic [4:0] voxel_z;
  logic [7:0] tile_code;
  modport source (output valid, req_type, voxel_x, voxel_y, voxel_z, tile_code,
                  input ready);
  modport sink (input valid, req_type, voxel_x, voxel_y, voxel_z, tile_code,
                output ready);
endinterface

interface vfc_vert_if;
  logic       valid;
  logic       ready;
  logic [5:0] vert_x;
  logic [5:0] vert_y;
  logic [5:0] vert_z;
  logic [2:0] face_dir;
  logic [7:0] face_tile;
  logic       tex_u_high;
  logic       tex_v_high;
  logic       last_vertex;
  modport source (output valid, vert_x, vert_y, vert_z, face_dir, face_tile,
                  tex_u_high, tex_v_high, last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, face_dir, face_tile,
                tex_u_high, tex_v_high, last_vertex, output ready);
endinterface

// File: rtl/voxel_face_cull_mesher_top.sv
// voxel face culling mesher top: apb extent registers, controller, datapath
// write item: grid write when taken; mesh item: grid reads, a face select step, then one
// vertex per cycle while vert.ready is high, up to 36 vertices; an empty voxel ends the
// item after its center read; one grid memory port bounds the read phase; one item in
// flight at a time; rst (sync) runs a clearing pass over 2^(3*clog2(GRID_DIM)) entries
// (32768 by default), taking no item; apb writes taken throughout, extents reset to 32
module voxel_face_cull_mesher_top #(
  parameter int GRID_DIM  = 32,
  parameter int TILE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  vfc_req_if.sink     req,
  vfc_vert_if.source  vert,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  vfc_pkg::ext_t ext;
  vfc_pkg::cmd_t cmd;
  vfc_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext.x <= 6'd32;
      ext.y <= 6'd32;
      ext.z <= 6'd32;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        vfc_pkg::REG_EXT_X: ext.x <= pwdata[5:0];
        vfc_pkg::REG_EXT_Y: ext.y <= pwdata[5:0];
        vfc_pkg::REG_EXT_Z: ext.z <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vfc_pkg::REG_EXT_X: prdata = 32'(ext.x);
      vfc_pkg::REG_EXT_Y: prdata = 32'(ext.y);
      vfc_pkg::REG_EXT_Z: prdata = 32'(ext.z);
      default:            prdata = '0;
    endcase
  end

  vfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_mesh   (req.req_type),
    .in_ready  (req.ready),
    .out_valid (vert.valid),
    .out_ready (vert.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vfc_dpath #(.GRID_DIM(GRID_DIM), .TILE_BITS(TILE_BITS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .ext         (ext),
    .req_type    (req.req_type),
    .voxel_x     (req.voxel_x),
    .voxel_y     (req.voxel_y),
    .voxel_z     (req.voxel_z),
    .tile_code   (req.tile_code),
    .vert_x      (vert.vert_x),
    .vert_y      (vert.vert_y),
    .vert_z      (vert.vert_z),
    .face_dir    (vert.face_dir),
    .face_tile   (vert.face_tile),
    .tex_u_high  (vert.tex_u_high),
    .tex_v_high  (vert.tex_v_high),
    .last_vertex (vert.last_vertex)
  );

endmodule

// File: rtl/vfc_ram.sv
// generic single port ram with registered read
// no dependencies
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/vfc_dpath.sv
// datapath: grid memory, request registers, face flags, vertex generation
// uses vfc_pkg and vfc_ram
module vfc_dpath #(
  parameter int GRID_DIM  = 32,
  parameter int TILE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  vfc_pkg::cmd_t      cmd,
  output vfc_pkg::sts_t      sts,
  input  vfc_pkg::ext_t      ext,
  input  logic               req_type,
  input  logic [4:0]         voxel_x,
  input  logic [4:0]         voxel_y,
  input  logic [4:0]         voxel_z,
  input  logic [7:0]         tile_code,
  output logic [5:0]         vert_x,
  output logic [5:0]         vert_y,
  output logic [5:0]         vert_z,
  output logic [2:0]         face_dir,
  output logic [7:0]         face_tile,
  output logic               tex_u_high,
  output logic               tex_v_high,
  output logic               last_vertex
);

  localparam int CW    = $clog2(GRID_DIM);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int CWX   = (CW > 6) ? CW : 6;
  localparam logic [8:0] DIM9 = 9'(GRID_DIM);

  function automatic logic in_grid(logic [5:0] a, logic [5:0] b, logic [5:0] c);
    in_grid = (9'(a) < DIM9) && (9'(b) < DIM9) && (9'(c) < DIM9);
  endfunction

  function automatic logic [AW-1:0] grid_addr(logic [5:0] a, logic [5:0] b,
                                              logic [5:0] c);
    logic [CWX-1:0] ae;
    logic [CWX-1:0] be;
    logic [CWX-1:0] ce;
    ae = CWX'(a);
    be = CWX'(b);
    ce = CWX'(c);
    grid_addr = {ce[CW-1:0], be[CW-1:0], ae[CW-1:0]};
  endfunction

  logic [5:0]           cx, cy, cz;
  logic [TILE_BITS-1:0] tile;
  logic [5:0]           open_f;
  logic [2:0]           rd_idx;
  logic [2:0]           face;
  logic [2:0]           corner;
  logic [AW-1:0]        clr_cnt;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [TILE_BITS-1:0] ram_wdata;
  logic [TILE_BITS-1:0] ram_rdata;

  // neighbour across the face selected by the read index
  logic [2:0] rd_face;
  logic [5:0] nx, ny, nz;
  logic       edge_open;

  always_comb begin
    rd_face   = rd_idx - 3'd1;
    nx        = cx;
    ny        = cy;
    nz        = cz;
    edge_open = 1'b0;
    if (rd_idx != vfc_pkg::CENTER_READ) begin
      unique case (rd_face)
        vfc_pkg::FACE_LEFT: begin
          nx = cx - 6'd1;
          edge_open = (cx == 6'd0);
        end
        vfc_pkg::FACE_RIGHT: begin
          nx = cx + 6'd1;
          edge_open = (7'(cx) + 7'd1 >= 7'(ext.x));
        end
        vfc_pkg::FACE_BOTTOM: begin
          ny = cy - 6'd1;
          edge_open = (cy == 6'd0);
        end
        vfc_pkg::FACE_TOP: begin
          ny = cy + 6'd1;
          edge_open = (7'(cy) + 7'd1 >= 7'(ext.y));
        end
        vfc_pkg::FACE_BACK: begin
          nz = cz - 6'd1;
          edge_open = (cz == 6'd0);
        end
        vfc_pkg::FACE_FRONT: begin
          nz = cz + 6'd1;
          edge_open = (7'(cz) + 7'd1 >= 7'(ext.z));
        end
        default: begin
          edge_open = 1'b1;
        end
      endcase
    end
  end

  // memory port select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = grid_addr(nx, ny, nz);
    ram_wdata = TILE_BITS'(tile_code);
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt;
      ram_wdata = '0;
    end else if (cmd.accept && !req_type) begin
      ram_we   = in_grid(6'(voxel_x), 6'(voxel_y), 6'(voxel_z));
      ram_addr = grid_addr(6'(voxel_x), 6'(voxel_y), 6'(voxel_z));
    end
  end

  vfc_ram #(.WIDTH(TILE_BITS), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next open face at or after the start index
  logic [2:0] start_f;
  logic [2:0] next_f;
  logic       next_found;

  always_comb begin
    start_f    = cmd.emit_init ? 3'd0 : face + 3'd1;
    next_f     = 3'd0;
    next_found = 1'b0;
    for (int i = 5; i >= 0; i--) begin
      if (open_f[i] && (3'(i) >= start_f)) begin
        next_f     = 3'(i);
        next_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rd_idx  <= '0;
      face    <= '0;
      corner  <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.accept && req_type) begin
        cx     <= 6'(voxel_x);
        cy     <= 6'(voxel_y);
        cz     <= 6'(voxel_z);
        rd_idx <= vfc_pkg::CENTER_READ;
      end
      if (cmd.capture) begin
        rd_idx <= rd_idx + 3'd1;
        if (rd_idx == vfc_pkg::CENTER_READ) begin
          tile <= ram_rdata;
        end else begin
          open_f[rd_face] <= edge_open || !in_grid(nx, ny, nz) || (ram_rdata == '0);
        end
      end
      if (cmd.emit_init) begin
        face   <= next_f;
        corner <= '0;
      end else if (cmd.emit_step) begin
        if (corner == vfc_pkg::LAST_CORNER) begin
          face   <= next_f;
          corner <= '0;
        end else begin
          corner <= corner + 3'd1;
        end
      end
    end
  end

  logic [4:0] crn;
  assign crn = vfc_pkg::CORNER_TAB[face][corner];

  assign vert_x      = cx + 6'(crn[4]);
  assign vert_y      = cy + 6'(crn[3]);
  assign vert_z      = cz + 6'(crn[2]);
  assign face_dir    = face;
  assign face_tile   = 8'(tile);
  assign tex_u_high  = crn[1];
  assign tex_v_high  = crn[0];
  assign last_vertex = (corner == vfc_pkg::LAST_CORNER) && !next_found;

  assign sts.clr_done     = &clr_cnt;
  assign sts.center_empty = (ram_rdata == '0) || !in_grid(cx, cy, cz);
  assign sts.rd_last      = (rd_idx == vfc_pkg::LAST_READ);
  assign sts.any_open     = |open_f;
  assign sts.emit_last    = last_vertex;

endmodule

// File: rtl/vfc_ctrl.sv
// controller state machine: clearing pass, request intake, grid reads, emission
// uses vfc_pkg
module vfc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_mesh,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vfc_pkg::cmd_t cmd,
  input  vfc_pkg::sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_CAPT  = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_mesh) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        if (!sts.rd_last && sts.center_empty && !cmd.issue) begin
          state_next = S_ISSUE;
        end
        // center read is the only one where an empty result ends the item
        state_next = S_ISSUE;
        if (sts.rd_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.emit_init = 1'b1;
        state_next    = sts.any_open ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
        if (out_ready && sts.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // empty center voxel ends the item after its read
  logic center_pass;
  logic center_stop;
  assign center_stop = (state == S_CAPT) && center_pass && sts.center_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      center_pass <= 1'b0;
    end else begin
      state <= center_stop ? S_IDLE : state_next;
      if (cmd.accept) begin
        center_pass <= 1'b1;
      end else if (cmd.capture) begin
        center_pass <= 1'b0;
      end
    end
  end

endmodule
